// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Both assume a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset
`define ASSERT_AT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ffla_pkg.sv =====
// Shared types, constants and helper functions for the free list allocator.
// No dependencies; used by ffla_ctrl, ffla_datapath and the top level.
`timescale 1ns / 1ps

package ffla_pkg;

    // Link memory geometry
    localparam int MAX_SLOTS = 256;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int LINK_W    = SLOT_W + 1;
    localparam int CNT_W     = LINK_W;

    // Link value meaning "no next slot"
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(MAX_SLOTS);

    typedef enum logic [1:0] {
        OP_TAKE  = 2'd0,
        OP_GIVE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_BAD_SLOT = 2'd2
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;     // input transaction taken this cycle
        logic commit;     // retire the transaction and load the output register
        logic cfg_write;  // slot count written, relink everything
    } cmd_t;

    // Slot count as used: zero acts as one, oversize acts as MAX_SLOTS
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] value);
        logic [CNT_W-1:0] res;
        res = value;
        if (value == '0)
            res = CNT_W'(1);
        else if (value > CNT_W'(MAX_SLOTS))
            res = CNT_W'(MAX_SLOTS);
        return res;
    endfunction

    // Link of a slot right after a relink
    function automatic logic [LINK_W-1:0] init_link(input logic [SLOT_W-1:0] idx,
                                                    input logic [CNT_W-1:0]  n);
        logic [LINK_W-1:0] succ;
        succ = LINK_W'(idx) + LINK_W'(1);
        return (CNT_W'(succ) < n) ? succ : LINK_NONE;
    endfunction

endpackage

// ===== hw/rtl/ffla_ctrl.sv =====
// Controller for the free list allocator: two-state sequencer and output valid.
// Depends on ffla_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffla_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    output ffla_pkg::cmd_t  cmd
);
    import ffla_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept, commit;

    // Handshakes
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign commit    = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    assign cmd.accept    = accept;
    assign cmd.commit    = commit;
    assign cmd.cfg_write = cfg_valid;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (commit)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register occupancy; a commit refills it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_NEXT(a_accept_to_exec, accept, state_reg == S_EXEC, "accept did not start execution")
    `ASSERT_NEXT(a_commit_fills_out, commit, out_valid_reg, "commit left output empty")
    `ASSERT_AT(a_commit_needs_room, commit |-> (!out_valid_reg || out_ready), "commit overwrote result")

endmodule

// ===== hw/rtl/ffla_datapath.sv =====
// Datapath for the free list allocator: link memory, head/tail/count, output register.
// Depends on ffla_pkg and assert_macros.svh; driven by commands from ffla_ctrl.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffla_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ffla_pkg::cmd_t                cmd,
    input  logic [1:0]                    op,
    input  logic [ffla_pkg::SLOT_W-1:0]   slot,
    input  logic [ffla_pkg::CNT_W-1:0]    cfg_data,
    output logic [1:0]                    status,
    output logic [ffla_pkg::SLOT_W-1:0]   taken_slot,
    output logic [ffla_pkg::CNT_W-1:0]    free_slots
);
    import ffla_pkg::*;

    // Architectural state
    logic [CNT_W-1:0]     slot_count_reg, slot_count_next;
    logic [LINK_W-1:0]    head_reg, head_next;
    logic [LINK_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic [MAX_SLOTS-1:0] valid_reg, valid_next;

    // Captured transaction
    op_t                  op_reg, op_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;

    // Result register
    status_t              out_status_reg, out_status_next;
    logic [SLOT_W-1:0]    out_taken_reg, out_taken_next;
    logic [CNT_W-1:0]     out_free_reg, out_free_next;

    // Link memory and its registered read
    logic [LINK_W-1:0]    link_mem [MAX_SLOTS];
    logic [LINK_W-1:0]    mem_rd_reg;
    logic                 mem_vld_reg;
    logic [LINK_W-1:0]    mem_dflt_reg;
    logic [LINK_W-1:0]    link_q;

    logic                 wr_en;
    logic [SLOT_W-1:0]    wr_addr;
    logic [LINK_W-1:0]    wr_data;

    logic [CNT_W-1:0]     n, n_cfg;
    logic                 list_empty;
    logic                 in_give_ok, give_ok;
    logic                 relink;
    status_t              res_status;
    logic [SLOT_W-1:0]    res_taken;

    assign n          = eff_count(slot_count_reg);
    assign n_cfg      = eff_count(cfg_data);
    assign list_empty = head_reg[SLOT_W] | tail_reg[SLOT_W];
    assign in_give_ok = (CNT_W'(slot) < n);
    assign give_ok    = (CNT_W'(slot_reg) < n);
    assign link_q     = mem_vld_reg ? mem_rd_reg : mem_dflt_reg;
    assign relink     = cmd.cfg_write || (cmd.commit && (op_reg == OP_CLEAR));

    // Capture the transaction at accept
    assign op_next   = cmd.accept ? op_t'(op) : op_reg;
    assign slot_next = cmd.accept ? slot : slot_reg;

    // Link memory write port: tail link at accept, new tail's link at commit
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = tail_reg[SLOT_W-1:0];
        wr_data = LINK_W'(slot);
        if (cmd.accept && (op_t'(op) == OP_GIVE) && in_give_ok && !list_empty)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.commit && (op_reg == OP_GIVE) && give_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = slot_reg;
            wr_data = LINK_NONE;
        end
    end

    // Per-slot written marks; unwritten slots read as the relinked chain
    always_comb
    begin
        valid_next = valid_reg;
        if (relink)
            valid_next = '0;
        else if (wr_en)
            valid_next[wr_addr] = 1'b1;
    end

    // Head, tail, count and result
    always_comb
    begin
        slot_count_next = slot_count_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        total_next      = total_reg;
        res_status      = ST_OK;
        res_taken       = '0;
        if (cmd.cfg_write)
        begin
            slot_count_next = cfg_data;
            head_next       = '0;
            tail_next       = LINK_W'(n_cfg - CNT_W'(1));
            total_next      = n_cfg;
        end
        else if (cmd.commit)
        begin
            unique case (op_reg)
                OP_TAKE:
                begin
                    if (head_reg[SLOT_W])
                    begin
                        res_status = ST_EMPTY;
                    end
                    else
                    begin
                        res_taken = head_reg[SLOT_W-1:0];
                        if (link_q[SLOT_W])
                        begin
                            head_next = LINK_NONE;
                            tail_next = LINK_NONE;
                        end
                        else
                        begin
                            head_next = link_q;
                        end
                        if (total_reg != '0)
                            total_next = total_reg - CNT_W'(1);
                    end
                end
                OP_GIVE:
                begin
                    if (!give_ok)
                    begin
                        res_status = ST_BAD_SLOT;
                    end
                    else
                    begin
                        if (list_empty)
                            head_next = LINK_W'(slot_reg);
                        tail_next = LINK_W'(slot_reg);
                        if (total_reg < n)
                            total_next = total_reg + CNT_W'(1);
                    end
                end
                OP_CLEAR:
                begin
                    head_next  = '0;
                    tail_next  = LINK_W'(n - CNT_W'(1));
                    total_next = n;
                end
                OP_NOP:
                begin
                    res_status = ST_OK;
                end
                default:
                begin
                    res_status = ST_OK;
                end
            endcase
        end
    end

    // Output register loads at commit
    assign out_status_next = cmd.commit ? res_status : out_status_reg;
    assign out_taken_next  = cmd.commit ? res_taken  : out_taken_reg;
    assign out_free_next   = cmd.commit ? total_next : out_free_reg;

    assign status     = out_status_reg;
    assign taken_slot = out_taken_reg;
    assign free_slots = out_free_reg;

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= CNT_W'(MAX_SLOTS);
            head_reg       <= '0;
            tail_reg       <= LINK_W'(MAX_SLOTS - 1);
            total_reg      <= CNT_W'(MAX_SLOTS);
            valid_reg      <= '0;
            op_reg         <= OP_NOP;
            slot_reg       <= '0;
            out_status_reg <= ST_OK;
            out_taken_reg  <= '0;
            out_free_reg   <= '0;
        end
        else
        begin
            slot_count_reg <= slot_count_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            total_reg      <= total_next;
            valid_reg      <= valid_next;
            op_reg         <= op_next;
            slot_reg       <= slot_next;
            out_status_reg <= out_status_next;
            out_taken_reg  <= out_taken_next;
            out_free_reg   <= out_free_next;
        end
    end

    // Link memory: one write, one registered read at the head
    always_ff @(posedge clk)
    begin
        if (wr_en)
            link_mem[wr_addr] <= wr_data;
        mem_rd_reg   <= link_mem[head_reg[SLOT_W-1:0]];
        mem_vld_reg  <= valid_reg[head_reg[SLOT_W-1:0]];
        mem_dflt_reg <= init_link(head_reg[SLOT_W-1:0], n);
    end

    `ASSERT_AT(a_head_tail_agree, head_reg[SLOT_W] == tail_reg[SLOT_W], "head and tail disagree on empty")
    `ASSERT_AT(a_total_bound, total_reg <= CNT_W'(MAX_SLOTS), "free count above capacity")
    `ASSERT_AT(a_taken_only_ok, (out_status_reg != ST_OK) |-> (out_taken_reg == '0), "slot given on failure")

endmodule

// ===== hw/rtl/fifo_free_list_allocator.sv =====
// Free list slot allocator, top level: joins controller and datapath.
// Depends on ffla_pkg, ffla_ctrl and ffla_datapath.
`timescale 1ns / 1ps

// Every transaction (take, give, clear, no-op) has an accept and a commit: the
// accept cycle issues the link memory read at the head (a give also writes the
// old tail's link there), and the commit loads the result register. The link
// memory, with one write port and one registered read, sets this order, so a
// new transaction is accepted only after the previous one has committed. A new
// transaction is accepted while an earlier result still waits in the output
// register; its commit waits until that register drains. Clear and slot_count
// writes relink all slots at once through per-slot written marks, so there
// is no clearing pass after reset. The slot_count port is always ready and is
// to be written only while the block is idle.
module fifo_free_list_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    op,
    input  logic [ffla_pkg::SLOT_W-1:0]   slot,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [ffla_pkg::SLOT_W-1:0]   taken_slot,
    output logic [ffla_pkg::CNT_W-1:0]    free_slots,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ffla_pkg::CNT_W-1:0]    cfg_data
);
    import ffla_pkg::*;

    cmd_t cmd;

    // Sequencer
    ffla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    // List state and link memory
    ffla_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .op         (op),
        .slot       (slot),
        .cfg_data   (cfg_data),
        .status     (status),
        .taken_slot (taken_slot),
        .free_slots (free_slots)
    );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for fifo_free_list_allocator: random take, give and clear traffic
// with random stalls on both sides, checked against a behavioral free list kept here.
// Depends on ffla_pkg and the fifo_free_list_allocator RTL.
`timescale 1ns / 1ps

module testbench;

    import ffla_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int NUM_PHASES     = 9;

    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] slot;
    } alloc_req_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] taken;
        logic [CNT_W-1:0]  free_cnt;
    } alloc_rsp_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         op = '0;
    logic [SLOT_W-1:0]  slot = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic [SLOT_W-1:0]  taken_slot;
    logic [CNT_W-1:0]   free_slots;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CNT_W-1:0]   cfg_data = '0;

    // Behavioral copy of the free list
    logic [LINK_W-1:0]  link_mem [MAX_SLOTS];
    logic [LINK_W-1:0]  free_head;
    logic [LINK_W-1:0]  free_tail;
    logic [CNT_W-1:0]   free_total;
    logic [CNT_W-1:0]   slot_count_reg;

    alloc_req_t         pending_reqs [$];
    alloc_rsp_t         expected_rsps [$];
    logic [SLOT_W-1:0]  held_slots [$];   // slots handed out and not yet returned

    alloc_req_t         next_req;
    alloc_rsp_t         predicted;
    logic               req_taken = 1'b0;
    logic               rsp_taken = 1'b0;
    int                 req_hold = 0;
    int                 req_run = 0;
    int                 rsp_hold = 0;
    int                 rsp_run = 0;
    int                 quiet_cycles = 0;
    int                 mismatches = 0;

    fifo_free_list_allocator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .slot       (slot),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .taken_slot (taken_slot),
        .free_slots (free_slots),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Slot count in effect: zero acts as one, oversize as the full memory
    function automatic int usable_slots();
        if (slot_count_reg == '0)
            return 1;
        if (slot_count_reg > CNT_W'(MAX_SLOTS))
            return MAX_SLOTS;
        return int'(slot_count_reg);
    endfunction

    // Wait per transaction, with occasional runs of back-to-back traffic
    function automatic int draw_gap(inout int run_left);
        if (run_left > 0)
        begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            run_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    // Chain every slot in order, last one ends the list
    task automatic relink_all();
        int n;
        n = usable_slots();
        for (int i = 0; i < MAX_SLOTS; i++)
            link_mem[i] = (i + 1 < n) ? LINK_W'(i + 1) : LINK_NONE;
        free_head  = '0;
        free_tail  = LINK_W'(n - 1);
        free_total = CNT_W'(n);
    endtask

    // Expected result of one transaction; updates the list copy
    task automatic predict_alloc(input alloc_req_t req, output alloc_rsp_t rsp);
        int n;
        logic [LINK_W-1:0] pick;
        n = usable_slots();
        rsp.status = ST_OK;
        rsp.taken  = '0;
        case (req.op)
            OP_TAKE:
            begin
                if (free_head >= LINK_W'(MAX_SLOTS))
                    rsp.status = ST_EMPTY;
                else
                begin
                    pick      = free_head;
                    rsp.taken = pick[SLOT_W-1:0];
                    free_head = link_mem[pick[SLOT_W-1:0]];
                    if (free_head >= LINK_W'(MAX_SLOTS))
                    begin
                        free_head = LINK_NONE;
                        free_tail = LINK_NONE;
                    end
                    // counter floors at zero
                    if (free_total > 0)
                        free_total--;
                end
            end
            OP_GIVE:
            begin
                if (int'(req.slot) >= n)
                    rsp.status = ST_BAD_SLOT;
                else
                begin
                    if (free_head >= LINK_W'(MAX_SLOTS) || free_tail >= LINK_W'(MAX_SLOTS))
                        free_head = LINK_W'(req.slot);
                    else
                        link_mem[free_tail[SLOT_W-1:0]] = LINK_W'(req.slot);
                    link_mem[req.slot] = LINK_NONE;
                    free_tail = LINK_W'(req.slot);
                    // double gives are not caught, the count just saturates
                    if (int'(free_total) < n)
                        free_total++;
                end
            end
            OP_CLEAR:
                relink_all();
            default:
            begin
            end
        endcase
        rsp.free_cnt = free_total;
    endtask

    // Compare one result transaction against the oldest prediction
    task automatic check_result();
        alloc_rsp_t want;
        if (expected_rsps.size() == 0)
        begin
            $display("%0t unexpected result: status %0d taken_slot %0d free_slots %0d",
                     $time, status, taken_slot, free_slots);
            mismatches++;
        end
        else
        begin
            want = expected_rsps.pop_front();
            if (status !== want.status)
            begin
                $display("%0t status: expected %0d actual %0d", $time, want.status, status);
                mismatches++;
            end
            if (taken_slot !== want.taken)
            begin
                $display("%0t taken_slot: expected %0d actual %0d",
                         $time, want.taken, taken_slot);
                mismatches++;
            end
            if (free_slots !== want.free_cnt)
            begin
                $display("%0t free_slots: expected %0d actual %0d",
                         $time, want.free_cnt, free_slots);
                mismatches++;
            end
        end
    endtask

    // Monitor: sample handshakes, check results, predict, watchdog
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_taken = 1'b0;
            rsp_taken = 1'b0;
        end
        else
        begin
            req_taken = in_valid && in_ready;
            rsp_taken = out_valid && out_ready;
            if (rsp_taken)
                check_result();
            if (req_taken)
            begin
                next_req.op   = op_t'(op);
                next_req.slot = slot;
                predict_alloc(next_req, predicted);
                expected_rsps.push_back(predicted);
                if (next_req.op == OP_TAKE && predicted.status == ST_OK)
                    held_slots.push_back(predicted.taken);
                else if (next_req.op == OP_CLEAR)
                    held_slots.delete();
            end
            if (cfg_valid && cfg_ready)
            begin
                slot_count_reg = cfg_data;
                relink_all();
                held_slots.delete();
            end
            if (req_taken || rsp_taken || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
                $display("fifo_free_list_allocator regression: fail");
                $finish;
            end
        end
    end

    // Request driver
    alloc_req_t drv_req;
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !req_taken)
        begin
            // hold the transaction until accepted
        end
        else if (req_hold > 0)
        begin
            req_hold--;
            in_valid <= 1'b0;
        end
        else if (pending_reqs.size() > 0)
        begin
            drv_req = pending_reqs.pop_front();
            op       <= drv_req.op;
            slot     <= drv_req.slot;
            in_valid <= 1'b1;
            req_hold = draw_gap(req_run);
        end
        else
            in_valid <= 1'b0;
    end

    // Result side back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (rsp_taken)
                rsp_hold = draw_gap(rsp_run);
            if (rsp_hold > 0)
            begin
                rsp_hold--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Step just past the sampling edge
    task automatic settle();
        @(posedge clk);
        #1;
    endtask

    // Let all traffic finish, then settle
    task automatic drain();
        do
            settle();
        while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0);
        repeat (4) settle();
    endtask

    task automatic write_slot_count(input logic [CNT_W-1:0] value);
        @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_op(input op_t kind, input int idx);
        alloc_req_t req;
        req.op   = kind;
        req.slot = SLOT_W'(idx);
        pending_reqs.push_back(req);
    endtask

    // One random transaction, mostly well-formed take/give traffic
    task automatic make_item(input int take_pct, output alloc_req_t req);
        int n;
        int roll;
        int idx;
        int hits [$];
        n    = usable_slots();
        roll = $urandom_range(0, 99);
        req.slot = SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
        if (roll < 3)
            req.op = OP_CLEAR;
        else if (roll < 6)
            req.op = OP_NOP;
        else if (roll < 10)
        begin
            // out-of-range give; at full size this becomes a stray give
            req.op = OP_GIVE;
            if (n < MAX_SLOTS)
                req.slot = SLOT_W'($urandom_range(n, MAX_SLOTS - 1));
        end
        else if (roll < 14)
        begin
            // stray give of any valid slot, possibly one already free
            req.op   = OP_GIVE;
            req.slot = SLOT_W'($urandom_range(0, n - 1));
            hits = held_slots.find_first_index(x) with (x == req.slot);
            if (hits.size() > 0)
                held_slots.delete(hits[0]);
        end
        else if (held_slots.size() > 0 && $urandom_range(0, 99) >= take_pct)
        begin
            req.op   = OP_GIVE;
            idx      = $urandom_range(0, held_slots.size() - 1);
            req.slot = held_slots[idx];
            held_slots.delete(idx);
        end
        else
            req.op = OP_TAKE;
    endtask

    logic [CNT_W-1:0] phase_size [NUM_PHASES];
    int               phase_items [NUM_PHASES];
    alloc_req_t       gen_req;
    int               take_pct;

    initial
    begin
        phase_size  = '{9'd5, 9'd0, 9'd2, 9'd256, 9'd17, 9'd511, 9'd3, 9'd8, 9'd1};
        phase_items = '{70, 40, 60, 140, 80, 50, 60, 60, 30};
        phase_size[7] = CNT_W'($urandom_range(4, 64));
        slot_count_reg = CNT_W'(MAX_SLOTS);
        relink_all();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        settle();

        // Full size after reset: pops, returns, stray give, no-op, clear
        queue_op(OP_TAKE, 0);
        queue_op(OP_TAKE, 200);
        queue_op(OP_GIVE, 0);
        queue_op(OP_GIVE, 255);
        queue_op(OP_NOP, 255);
        queue_op(OP_CLEAR, 0);
        queue_op(OP_TAKE, 0);
        drain();

        // Two slots: run dry, bad slots, double give at tail, saturation
        write_slot_count(9'd2);
        queue_op(OP_TAKE, 0);
        queue_op(OP_TAKE, 0);
        queue_op(OP_TAKE, 0);
        queue_op(OP_GIVE, 2);
        queue_op(OP_GIVE, 255);
        queue_op(OP_GIVE, 1);
        queue_op(OP_GIVE, 1);
        queue_op(OP_GIVE, 0);
        queue_op(OP_TAKE, 0);
        queue_op(OP_TAKE, 0);
        queue_op(OP_TAKE, 0);
        queue_op(OP_NOP, 0);
        drain();

        // Random phases over several slot counts
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_slot_count(phase_size[p]);
            take_pct = 50;
            for (int k = 0; k < phase_items[p]; k++)
            begin
                if (k % 32 == 0)
                    take_pct = ($urandom_range(0, 1) != 0) ? 75 : 30;
                do
                    settle();
                while (pending_reqs.size() >= 2);
                make_item(take_pct, gen_req);
                pending_reqs.push_back(gen_req);
            end
            drain();
        end

        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("fifo_free_list_allocator regression: pass");
        else
            $display("fifo_free_list_allocator regression: fail");
        $finish;
    end

endmodule
